### src/utf8_stream_validator_unit_assert.svh
// Assertion macros shared by the UTF-8 validator RTL
`ifndef UTF8_STREAM_VALIDATOR_UNIT_ASSERT_SVH
`define UTF8_STREAM_VALIDATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is low
`define U8V_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("u8v assertion failed");
// Next-cycle implication, disabled while reset is low
`define U8V_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("u8v assertion failed");
`else
`define U8V_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define U8V_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### src/u8v_pkg.sv
// Types and constants for the UTF-8 stream validator
`default_nettype none
package u8v_pkg;

  // Byte range boundaries of the strict UTF-8 lead and continuation sets
  localparam logic [7:0] ASCII_MAX   = 8'h7F;
  localparam logic [7:0] CONT_MIN    = 8'h80;
  localparam logic [7:0] CONT_8F     = 8'h8F;
  localparam logic [7:0] CONT_90     = 8'h90;
  localparam logic [7:0] CONT_9F     = 8'h9F;
  localparam logic [7:0] CONT_A0     = 8'hA0;
  localparam logic [7:0] CONT_MAX    = 8'hBF;
  localparam logic [7:0] LEAD2_MIN   = 8'hC2;
  localparam logic [7:0] LEAD2_MAX   = 8'hDF;
  localparam logic [7:0] LEAD_E0     = 8'hE0;
  localparam logic [7:0] LEAD_ED     = 8'hED;
  localparam logic [7:0] LEAD3_MAX   = 8'hEF;
  localparam logic [7:0] LEAD_F0     = 8'hF0;
  localparam logic [7:0] LEAD_F4     = 8'hF4;

  // Byte class computed by the front end
  typedef enum logic [3:0] {
    CLS_ASCII,    // 00..7F
    CLS_C80_8F,   // continuation 80..8F
    CLS_C90_9F,   // continuation 90..9F
    CLS_CA0_BF,   // continuation A0..BF
    CLS_LEAD2,    // C2..DF
    CLS_E0,
    CLS_LEAD3,    // E1..EC, EE..EF
    CLS_ED,
    CLS_F0,
    CLS_LEAD4,    // F1..F3
    CLS_F4,
    CLS_BAD       // C0, C1, F5..FF
  } byte_cls_t;

  // Decoder states
  typedef enum logic [3:0] {
    ST_START,
    ST_NEED1,
    ST_NEED2,
    ST_NEED3,
    ST_AFT_E0,
    ST_AFT_ED,
    ST_AFT_F0,
    ST_AFT_F4,
    ST_ERROR
  } u8v_state_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } in_item_t;

  typedef struct packed {
    logic well_formed;
    logic malformed;
    logic end_marker;
  } out_item_t;

  // Entry of the queue between front and back
  typedef struct packed {
    byte_cls_t cls;
    logic      stream_end;
  } q_item_t;

  // Push or pop side of the queue
  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_side_t;

endpackage
`default_nettype wire

### src/u8v_front.sv
// Front end: accepts bytes and classifies them into byte classes
`default_nettype none
module u8v_front (
  input  wire  u8v_pkg::in_item_t in_data,
  input  wire  logic              in_valid,
  input  wire  logic              q_full,
  output logic                    in_stall,
  output u8v_pkg::q_side_t        push
);
  import u8v_pkg::*;

  logic [7:0] b;
  byte_cls_t  cls;

  assign b = in_data.data_byte;

  // Range decode of the byte
  always_comb begin
    if (b <= ASCII_MAX) begin
      cls = CLS_ASCII;
    end else if (b <= CONT_8F) begin
      cls = CLS_C80_8F;
    end else if (b <= CONT_9F) begin
      cls = CLS_C90_9F;
    end else if (b <= CONT_MAX) begin
      cls = CLS_CA0_BF;
    end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
      cls = CLS_LEAD2;
    end else if (b == LEAD_E0) begin
      cls = CLS_E0;
    end else if (b == LEAD_ED) begin
      cls = CLS_ED;
    end else if (b > LEAD_E0 && b <= LEAD3_MAX) begin
      cls = CLS_LEAD3;
    end else if (b == LEAD_F0) begin
      cls = CLS_F0;
    end else if (b > LEAD_F0 && b < LEAD_F4) begin
      cls = CLS_LEAD4;
    end else if (b == LEAD_F4) begin
      cls = CLS_F4;
    end else begin
      cls = CLS_BAD;
    end
  end

  // Transfer into the queue whenever it has room
  assign in_stall             = q_full;
  assign push.valid           = in_valid && !q_full;
  assign push.item.cls        = cls;
  assign push.item.stream_end = in_data.stream_end;

endmodule
`default_nettype wire

### src/u8v_queue.sv
// Short queue of classified bytes between front and back
`default_nettype none
`include "utf8_stream_validator_unit_assert.svh"
module u8v_queue #(
  parameter int DEPTH = 4
) (
  input  wire  logic             clk,
  input  wire  logic             rst_n,
  input  wire  u8v_pkg::q_side_t push,
  input  wire  logic             pop,
  output logic                   full,
  output u8v_pkg::q_side_t       head
);
  import u8v_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  q_item_t       mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_pop;

  assign full       = (count_r == CW'(DEPTH));
  assign head.valid = (count_r != '0);
  assign head.item  = mem_r[rd_ptr_r];
  assign do_pop     = pop && head.valid;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push.valid) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push.valid && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push.valid && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.item;
    end
  end

  `U8V_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(DEPTH))
  `U8V_ASSERT_IMP(a_no_push_full, clk, rst_n, full, !push.valid)
  `U8V_ASSERT_NXT(a_count_up, clk, rst_n, push.valid && !do_pop, count_r == $past(count_r) + 1'b1)

endmodule
`default_nettype wire

### src/u8v_back.sv
// Back end: DFA over byte classes and the result register
`default_nettype none
`include "utf8_stream_validator_unit_assert.svh"
module u8v_back (
  input  wire  logic             clk,
  input  wire  logic             rst_n,
  input  wire  u8v_pkg::q_side_t head,
  output logic                   pop,
  input  wire  logic             out_stall,
  output logic                   out_valid,
  output u8v_pkg::out_item_t     out_data
);
  import u8v_pkg::*;

  u8v_state_t state_r, state_nxt;
  u8v_state_t adv;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_data_r, out_data_nxt;
  logic       is_cont;

  // Take the next entry when the result register is free or being taken
  assign pop = head.valid && (!out_valid_r || !out_stall);

  assign is_cont = (head.item.cls == CLS_C80_8F) || (head.item.cls == CLS_C90_9F) ||
                   (head.item.cls == CLS_CA0_BF);

  // DFA transition for the head entry
  always_comb begin
    case (state_r)
      ST_START: begin
        case (head.item.cls)
          CLS_ASCII: adv = ST_START;
          CLS_LEAD2: adv = ST_NEED1;
          CLS_E0:    adv = ST_AFT_E0;
          CLS_LEAD3: adv = ST_NEED2;
          CLS_ED:    adv = ST_AFT_ED;
          CLS_F0:    adv = ST_AFT_F0;
          CLS_LEAD4: adv = ST_NEED3;
          CLS_F4:    adv = ST_AFT_F4;
          default:   adv = ST_ERROR;
        endcase
      end
      ST_NEED1:  adv = is_cont ? ST_START : ST_ERROR;
      ST_NEED2:  adv = is_cont ? ST_NEED1 : ST_ERROR;
      ST_NEED3:  adv = is_cont ? ST_NEED2 : ST_ERROR;
      // E0 rules out overlongs: A0..BF only
      ST_AFT_E0: adv = (head.item.cls == CLS_CA0_BF) ? ST_NEED1 : ST_ERROR;
      // ED rules out surrogates: 80..9F only
      ST_AFT_ED: adv = (head.item.cls == CLS_C80_8F || head.item.cls == CLS_C90_9F)
                       ? ST_NEED1 : ST_ERROR;
      // F0 rules out overlongs: 90..BF only
      ST_AFT_F0: adv = (head.item.cls == CLS_C90_9F || head.item.cls == CLS_CA0_BF)
                       ? ST_NEED2 : ST_ERROR;
      // F4 caps at U+10FFFF: 80..8F only
      ST_AFT_F4: adv = (head.item.cls == CLS_C80_8F) ? ST_NEED2 : ST_ERROR;
      default:   adv = ST_ERROR;
    endcase
  end

  // Next state and result register
  always_comb begin
    state_nxt     = state_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (pop) begin
      state_nxt                = head.item.stream_end ? ST_START : adv;
      out_data_nxt.well_formed = (adv == ST_START);
      out_data_nxt.malformed   = (adv == ST_ERROR);
      out_data_nxt.end_marker  = head.item.stream_end;
      out_valid_nxt            = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_START;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `U8V_ASSERT_IMP(a_flags_excl, clk, rst_n, out_valid_r, !(out_data_r.well_formed && out_data_r.malformed))
  `U8V_ASSERT_NXT(a_err_sticky, clk, rst_n, pop && state_r == ST_ERROR && !head.item.stream_end, state_r == ST_ERROR)
  `U8V_ASSERT_NXT(a_end_restart, clk, rst_n, pop && head.item.stream_end, state_r == ST_START && out_data_r.end_marker)

endmodule
`default_nettype wire

### src/utf8_stream_validator_unit.sv
// Top level of the UTF-8 stream validator
// UTF-8 well-formedness checker: takes one byte per cycle unless stalled and gives one result
// per byte (well_formed, malformed, end_marker). A transferred byte is classified and written
// to a queue of QUEUE_DEPTH entries; the decoder takes one entry per cycle while the result
// register is free or being taken and registers the result, so a result passes through the
// queue storage and then the result register before it is presented. The decoder updates its
// state once per entry, which sets the rate at one byte per cycle; in_stall rises only when the
// queue is full because the result side has been stalling. A byte with stream_end set returns
// the decoder to its start state after its own result, so the next byte opens a new stream.
`default_nettype none
module utf8_stream_validator_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire  logic                clk,
  input  wire  logic                rst_n,
  input  wire  logic                in_valid,
  output logic                      in_stall,
  input  wire  u8v_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire  logic                out_stall,
  output u8v_pkg::out_item_t        out_data
);
  import u8v_pkg::*;

  q_side_t push;
  q_side_t head;
  logic    q_full;
  logic    pop;

  // Classification side
  u8v_front u_front (
    .in_data  (in_data),
    .in_valid (in_valid),
    .q_full   (q_full),
    .in_stall (in_stall),
    .push     (push)
  );

  // Decoupling queue
  u8v_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .full  (q_full),
    .head  (head)
  );

  // Decoder side
  u8v_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
